// ----- hdl/esc_pkg.sv -----
// shared types, character codes and helpers for the expression syntax checker
package esc_pkg;

	// character classes of the previous non-space character
	localparam logic [2:0] CL_START  = 3'd0;
	localparam logic [2:0] CL_DIGIT  = 3'd1;
	localparam logic [2:0] CL_OP     = 3'd2;
	localparam logic [2:0] CL_MINUS  = 3'd3;
	localparam logic [2:0] CL_DOT    = 3'd4;
	localparam logic [2:0] CL_RPAREN = 3'd5;
	localparam logic [2:0] CL_OTHER  = 3'd6;

	// error codes, lowest wins within one item
	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_LEAD_OP     = 4'd1;
	localparam logic [3:0] ERR_LEAD_MINUS  = 4'd2;
	localparam logic [3:0] ERR_TRAIL_OP    = 4'd3;
	localparam logic [3:0] ERR_LEAD_DOT    = 4'd4;
	localparam logic [3:0] ERR_TRAIL_DOT   = 4'd5;
	localparam logic [3:0] ERR_MISMATCH    = 4'd6;
	localparam logic [3:0] ERR_UNCLOSED    = 4'd7;
	localparam logic [3:0] ERR_OVERFLOW    = 4'd8;
	localparam logic [3:0] ERR_OP_OP       = 4'd9;
	localparam logic [3:0] ERR_MINUS_OP    = 4'd10;
	localparam logic [3:0] ERR_OP_CLOSE    = 4'd11;
	localparam logic [3:0] ERR_DOT_NO_PRE  = 4'd12;
	localparam logic [3:0] ERR_SECOND_DOT  = 4'd13;
	localparam logic [3:0] ERR_DOT_NO_POST = 4'd14;
	localparam int         ERR_MAX         = 14;

	// bracket kinds held on the stack
	localparam logic [1:0] BK_PAREN  = 2'd0;
	localparam logic [1:0] BK_SQUARE = 2'd1;
	localparam logic [1:0] BK_CURLY  = 2'd2;

	// ascii codes
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LSQ    = 8'h5B;
	localparam logic [7:0] CH_RSQ    = 8'h5D;
	localparam logic [7:0] CH_LCURLY = 8'h7B;
	localparam logic [7:0] CH_RCURLY = 8'h7D;

	// request from the rule logic to the bracket stack
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clear;
		logic [1:0] kind;
	} stk_req_t;

	// stack status seen by the rule logic
	typedef struct packed {
		logic       empty;
		logic       full;
		logic       one;
		logic [1:0] top;
	} stk_status_t;

	// per-expression scan state
	typedef struct packed {
		logic [2:0] pclass;
		logic       pfirst;
		logic       dec_seen;
		logic [3:0] ferr;
	} lint_state_t;

	function automatic logic [2:0] classify(input logic [7:0] ch);
		logic [2:0] c;
		c = CL_OTHER;
		if (ch >= CH_ZERO && ch <= CH_NINE) c = CL_DIGIT;
		else if (ch == CH_PLUS || ch == CH_STAR || ch == CH_SLASH || ch == CH_CARET) c = CL_OP;
		else if (ch == CH_MINUS) c = CL_MINUS;
		else if (ch == CH_DOT) c = CL_DOT;
		else if (ch == CH_RPAREN) c = CL_RPAREN;
		return c;
	endfunction

endpackage

// ----- hdl/expression_syntax_checker.sv -----
// top level of the streaming expression syntax checker
//
// channel  dir  tdata                          tlast      tuser
// s_axis   in   [7:0] character                last       -
// m_axis   out  [0] ok, [4:1] error_code, pad  final_res  -
//
// one item per cycle sustained while m_axis accepts results; each character passes
// through an input register, then one pass through the rule logic and the
// bracket stack into the result register
// the stack keeps its top and next-below entries in registers so a push or
// pop every cycle needs one memory write or one registered read
// arst_n clears the scan state, the stack depth and both valid flags; stack
// contents stay undefined until pushed
// a stall on m_axis holds the result and lets one more item wait in the input
// register before s_tready drops
module expression_syntax_checker #(
	parameter int STACK_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] character
	input  logic       s_tlast,  // last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [0] ok, [4:1] error_code, [7:5] zero
	output logic       m_tlast   // final_res
);
	import esc_pkg::*;

	// input stage
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;

	// scan state carried from item to item
	lint_state_t state_q;
	lint_state_t state_nx;

	// rule logic outputs
	stk_req_t    stk_req;
	stk_status_t stk_stat;
	logic        ok_c;
	logic [3:0]  code_c;

	// result register
	logic        ok_s2;
	logic [3:0]  code_s2;
	logic        last_s2;

	logic        advance;

	// move the held character into the result register when it is free
	assign advance  = valid_s1 & (~m_tvalid | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	esc_lint u_lint (
		.character  (char_s1),
		.last       (last_s1),
		.cur        (state_q),
		.stk        (stk_stat),
		.req        (stk_req),
		.nxt        (state_nx),
		.ok         (ok_c),
		.error_code (code_c)
	);

	esc_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (stk_req),
		.status (stk_stat)
	);

	// scan state steps only when an item is actually processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pclass   <= CL_START;
			state_q.pfirst   <= 1'b0;
			state_q.dec_seen <= 1'b0;
			state_q.ferr     <= ERR_NONE;
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_s2   <= ok_c;
			code_s2 <= code_c;
			last_s2 <= last_s1;
		end
	end

	assign m_tdata = {3'b000, code_s2, ok_s2};
	assign m_tlast = last_s2;

endmodule

// ----- hdl/esc_stack.sv -----
// bracket stack: memory with registered top and next-below entries
module esc_stack #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  esc_pkg::stk_req_t  req,
	output esc_pkg::stk_status_t status
);
	import esc_pkg::*;

	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	logic [1:0]       mem [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nx;
	logic [CNT_W-1:0] rd_addr;
	logic [1:0]       top_q;
	logic [1:0]       below_q;
	logic             empty;
	logic             full;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(STACK_DEPTH));
	assign do_push = en & req.push & ~full;
	assign do_pop  = en & req.pop & ~empty;

	always_comb begin
		count_nx = count_q;
		if (en && req.clear) count_nx = '0;
		else if (do_push) count_nx = count_q + CNT_W'(1);
		else if (do_pop) count_nx = count_q - CNT_W'(1);
	end

	// entry two below the new count, prefetched for a following pop
	assign rd_addr = count_nx - CNT_W'(1) - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[count_q[IDX_W-1:0]] <= req.kind;
			top_q   <= req.kind;
			below_q <= top_q;
		end else begin
			if (do_pop) top_q <= below_q;
			if (count_nx > CNT_W'(1)) below_q <= mem[rd_addr[IDX_W-1:0]];
		end
	end

	assign status.empty = empty;
	assign status.full  = full;
	assign status.one   = (count_q == CNT_W'(1));
	assign status.top   = top_q;

endmodule

// ----- hdl/esc_lint.sv -----
// syntax rules for one character: error code, stack request and next scan state
module esc_lint (
	input  logic [7:0]            character,
	input  logic                  last,
	input  esc_pkg::lint_state_t  cur,
	input  esc_pkg::stk_status_t  stk,
	output esc_pkg::stk_req_t     req,
	output esc_pkg::lint_state_t  nxt,
	output logic                  ok,
	output logic [3:0]            error_code
);
	import esc_pkg::*;

	logic [2:0]       c;
	logic [2:0]       p;
	logic             live;
	logic             first;
	logic             is_open;
	logic             is_close;
	logic [1:0]       open_kind;
	logic [1:0]       want;
	logic             pushes;
	logic             left_open;
	logic [2:0]       eff_class;
	logic             eff_first;
	logic [ERR_MAX:1] flag;
	logic [3:0]       err;
	logic [3:0]       ferr_nx;

	assign live  = (character != CH_SPACE);
	assign c     = classify(character);
	assign p     = cur.pclass;
	assign first = (p == CL_START);

	assign is_open  = (character == CH_LPAREN) || (character == CH_LSQ) ||
	                  (character == CH_LCURLY);
	assign is_close = (character == CH_RPAREN) || (character == CH_RSQ) ||
	                  (character == CH_RCURLY);
	assign open_kind = (character == CH_LPAREN) ? BK_PAREN :
	                   (character == CH_LSQ) ? BK_SQUARE : BK_CURLY;
	assign want      = (character == CH_RPAREN) ? BK_PAREN :
	                   (character == CH_RSQ) ? BK_SQUARE : BK_CURLY;

	assign pushes = is_open & ~stk.full;

	assign req.push  = pushes;
	assign req.pop   = is_close;
	assign req.clear = last;
	assign req.kind  = open_kind;

	// trailing checks look at the last non-space character
	assign eff_class = live ? c : p;
	assign eff_first = live ? first : cur.pfirst;

	// whether any bracket stays open after this item's push or pop
	always_comb begin
		if (pushes) left_open = 1'b1;
		else if (is_close) left_open = ~stk.empty & ~stk.one;
		else left_open = ~stk.empty;
	end

	always_comb begin
		flag = '0;
		if (live) begin
			flag[ERR_LEAD_OP]     = first && c == CL_OP;
			flag[ERR_LEAD_MINUS]  = cur.pfirst && p == CL_MINUS && c != CL_DIGIT;
			flag[ERR_LEAD_DOT]    = first && c == CL_DOT;
			flag[ERR_MISMATCH]    = is_close && (stk.empty || stk.top != want);
			flag[ERR_OVERFLOW]    = is_open && stk.full;
			flag[ERR_OP_OP]       = p == CL_OP && c == CL_OP;
			flag[ERR_MINUS_OP]    = p == CL_MINUS && c == CL_OP;
			flag[ERR_OP_CLOSE]    = p == CL_OP && c == CL_RPAREN;
			flag[ERR_DOT_NO_PRE]  = c == CL_DOT && !first && p != CL_DIGIT;
			flag[ERR_SECOND_DOT]  = c == CL_DOT && cur.dec_seen;
			flag[ERR_DOT_NO_POST] = p == CL_DOT && c != CL_DIGIT;
		end
		if (last) begin
			// a lone leading minus reports as leading minus, not trailing
			if (eff_class == CL_MINUS && eff_first) flag[ERR_LEAD_MINUS] = 1'b1;
			else if (eff_class == CL_OP || eff_class == CL_MINUS) flag[ERR_TRAIL_OP] = 1'b1;
			if (eff_class == CL_DOT) flag[ERR_TRAIL_DOT] = 1'b1;
			if (left_open) flag[ERR_UNCLOSED] = 1'b1;
		end
	end

	// lowest raised code
	always_comb begin
		err = ERR_NONE;
		for (int i = ERR_MAX; i >= 1; i--) begin
			if (flag[i]) err = 4'(i);
		end
	end

	assign ferr_nx    = (cur.ferr == ERR_NONE) ? err : cur.ferr;
	assign ok         = (ferr_nx == ERR_NONE);
	assign error_code = ferr_nx;

	always_comb begin
		nxt = cur;
		if (live) begin
			nxt.pclass = c;
			nxt.pfirst = first;
			if (c == CL_DOT) nxt.dec_seen = 1'b1;
			else if (c == CL_OP || c == CL_MINUS) nxt.dec_seen = 1'b0;
		end
		nxt.ferr = ferr_nx;
		if (last) begin
			nxt.pclass   = CL_START;
			nxt.pfirst   = 1'b0;
			nxt.dec_seen = 1'b0;
			nxt.ferr     = ERR_NONE;
		end
	end

endmodule
